FILE: rtl/sector_run_bitmap_allocator_assert.svh
// Assertion shorthands, clocked on clk and held off while rst_n is low.
`ifndef SECTOR_RUN_BITMAP_ALLOCATOR_ASSERT_SVH
`define SECTOR_RUN_BITMAP_ALLOCATOR_ASSERT_SVH

// consequent checked in the same cycle
`define SRA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sector run allocator: assertion failed");

// consequent checked in the cycle after the antecedent
`define SRA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sector run allocator: assertion failed");

`endif

FILE: rtl/sra_pkg.sv
package sra_pkg;

  localparam int LEN_W = 13;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FREE  = 3'd1;
  localparam logic [2:0] ST_USED     = 3'd2;
  localparam logic [2:0] ST_PAST_END = 3'd3;
  localparam logic [2:0] ST_NOT_USED = 3'd4;

  localparam logic REG_FIRST_DATA_SECTOR = 1'b0;
  localparam logic REG_MAP_SIZE_BITS     = 1'b1;

  localparam logic [15:0] MAP_SIZE_MASK = 16'hFFF8;
  localparam logic [7:0]  BYTE_FULL     = 8'hFF;

  typedef struct packed {
    logic clr;      // clearing pass: write one byte, advance
    logic load;     // capture input item
    logic prep;     // start of item: rewind address, work out start bit of a free
    logic scan;     // look at one map byte for a clear bit
    logic nofree;   // no clear bit in the map
    logic setup;    // set up the run walk from the start bit
    logic mark;     // allocate: set run bits of one byte
    logic check;    // free: check run bits of one byte
    logic unset;    // free: clear run bits of one byte
    logic finish;   // load result register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic len_zero;
    logic map_empty;
    logic byte_free;
    logic scan_last;
    logic range_bad;
    logic run_last;
    logic bad;
  } sts_t;

  // bits off .. off+take-1 of one byte
  function automatic logic [7:0] run_mask(logic [2:0] off, logic [3:0] take);
    logic [15:0] m;
    m = ((16'h1 << take) - 16'h1) << off;
    return m[7:0];
  endfunction

  // lowest clear bit among bits 0..6, else 7
  function automatic logic [2:0] first_zero(logic [7:0] v);
    logic [2:0] r;
    r = 3'd7;
    for (int k = 6; k >= 0; k--) begin
      if (!v[k]) r = 3'(k);
    end
    return r;
  endfunction

endpackage

FILE: rtl/sra_ctrl.sv
module sra_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  sra_pkg::sts_t sts,
  output sra_pkg::cmd_t cmd
);
  import sra_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_SCAN_RD, S_SCAN_EX, S_SETUP, S_RUN_RD, S_RUN_EX, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pass2_nxt     = pass2_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          pass2_nxt = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.len_zero) begin
          state_nxt = S_DONE;
        end else if (sts.is_free) begin
          state_nxt = S_SETUP;
        end else if (sts.map_empty) begin
          cmd.nofree = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EX;
      S_SCAN_EX: begin
        cmd.scan = 1'b1;
        if (sts.byte_free) begin
          state_nxt = S_SETUP;
        end else if (sts.scan_last) begin
          cmd.nofree = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.is_free && (sts.range_bad || (pass2_r && sts.bad))) state_nxt = S_DONE;
        else state_nxt = S_RUN_RD;
      end
      S_RUN_RD: state_nxt = S_RUN_EX;
      S_RUN_EX: begin
        if (!sts.is_free) begin
          cmd.mark = 1'b1;
          state_nxt = sts.run_last ? S_DONE : S_RUN_RD;
        end else if (!pass2_r) begin
          cmd.check = 1'b1;
          if (sts.run_last) begin
            pass2_nxt = 1'b1;
            state_nxt = S_SETUP;
          end else begin
            state_nxt = S_RUN_RD;
          end
        end else begin
          cmd.unset = 1'b1;
          state_nxt = sts.run_last ? S_DONE : S_RUN_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pass2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass2_r     <= pass2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/sra_dp.sv
module sra_dp #(
  parameter int MAP_BYTES = 4096,
  parameter int MAX_RUN   = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [31:0]                cfg_wdata,
  input  logic                       in_action,
  input  logic [31:0]                in_start_sector,
  input  logic [sra_pkg::LEN_W-1:0]  in_run_length,
  input  sra_pkg::cmd_t              cmd,
  output sra_pkg::sts_t              sts,
  output logic [31:0]                out_first_sector,
  output logic [2:0]                 out_status
);
  import sra_pkg::*;

  localparam int ABW = $clog2(MAP_BYTES);
  localparam int NBW = $clog2(MAP_BYTES + 1);
  localparam logic [31:0] CAP_BITS = 32'(MAP_BYTES * 8);
  localparam logic [31:0] MAX_RUN_W = 32'(MAX_RUN);

  logic [7:0] mem [MAP_BYTES];
  logic [7:0] rdata_r;

  logic [31:0] fds_r;
  logic [15:0] msb_r;

  logic             act_r;
  logic [31:0]      start_r;
  logic [LEN_W-1:0] len_r;
  logic [ABW-1:0]   addr_r;
  logic [2:0]       off_r;
  logic [LEN_W-1:0] rem_r;
  logic [31:0]      b0_r;
  logic [31:0]      first_r;
  logic             used_r, past_r, nofree_r;
  logic [31:0]      out_first_r;
  logic [2:0]       out_status_r;

  logic [31:0]      size_req, size32;
  logic [NBW-1:0]   nbytes;
  logic [LEN_W-1:0] lenc;
  logic [3:0]       avail, take;
  logic             rem_small;
  logic [7:0]       mask;
  logic             past_calc;
  logic             wr_en;
  logic [7:0]       wr_data;

  assign size_req = {16'b0, msb_r & MAP_SIZE_MASK};
  assign size32   = (size_req < CAP_BITS) ? size_req : CAP_BITS;
  assign nbytes   = size32[NBW+2:3];
  assign lenc     = ({19'b0, len_r} > MAX_RUN_W) ? MAX_RUN_W[LEN_W-1:0] : len_r;

  assign avail     = 4'd8 - {1'b0, off_r};
  assign rem_small = (rem_r <= {9'b0, avail});
  assign take      = rem_small ? rem_r[3:0] : avail;
  assign mask      = run_mask(off_r, take);
  assign past_calc = (b0_r + {19'b0, lenc}) > size32;

  assign sts.clr_last  = (addr_r == ABW'(MAP_BYTES - 1));
  assign sts.is_free   = (act_r == ACT_FREE);
  assign sts.len_zero  = (lenc == '0);
  assign sts.map_empty = (size32 == 32'd0);
  assign sts.byte_free = (rdata_r != BYTE_FULL);
  assign sts.scan_last = (NBW'(addr_r) == nbytes - NBW'(1));
  assign sts.range_bad = (b0_r >= size32) || ({19'b0, lenc} > (size32 - b0_r));
  assign sts.run_last  = rem_small;
  assign sts.bad       = used_r;

  assign wr_en = cmd.clr | cmd.mark | cmd.unset;
  always_comb begin
    if (cmd.clr) wr_data = (addr_r == '0) ? 8'h01 : 8'h00;
    else if (cmd.mark) wr_data = rdata_r | mask;
    else wr_data = rdata_r & ~mask;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_r] <= wr_data;
    rdata_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fds_r <= 32'd1;
      msb_r <= 16'd32768;
    end else if (cfg_we) begin
      if (cfg_addr == REG_FIRST_DATA_SECTOR) fds_r <= cfg_wdata;
      else if (cfg_addr == REG_MAP_SIZE_BITS) msb_r <= cfg_wdata[15:0];
    end
  end

  // addr_r doubles as the clearing pointer after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.clr) begin
      addr_r <= addr_r + ABW'(1);
    end else if (cmd.prep) begin
      addr_r <= '0;
    end else if (cmd.scan) begin
      if (!sts.byte_free) addr_r <= addr_r + ABW'(1);
    end else if (cmd.setup) begin
      addr_r <= b0_r[ABW+2:3];
    end else if (cmd.mark || cmd.check || cmd.unset) begin
      addr_r <= addr_r + ABW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      start_r  <= in_start_sector;
      len_r    <= in_run_length;
      used_r   <= 1'b0;
      past_r   <= 1'b0;
      nofree_r <= 1'b0;
      first_r  <= 32'd0;
    end
    if (cmd.prep) b0_r <= start_r - fds_r + 32'd1;
    if (cmd.scan && sts.byte_free) b0_r <= 32'({addr_r, first_zero(rdata_r)});
    if (cmd.nofree) nofree_r <= 1'b1;
    if (cmd.setup) begin
      off_r <= b0_r[2:0];
      if (act_r == ACT_FREE) begin
        rem_r  <= lenc;
        past_r <= sts.range_bad;
      end else begin
        rem_r   <= past_calc ? LEN_W'(size32 - b0_r) : lenc;
        past_r  <= past_calc;
        first_r <= b0_r + fds_r - 32'd1;
      end
    end
    if (cmd.mark || cmd.check || cmd.unset) begin
      off_r <= 3'd0;
      rem_r <= rem_r - {9'b0, take};
    end
    if (cmd.mark && ((rdata_r & mask) != 8'h00)) used_r <= 1'b1;
    if (cmd.check && ((rdata_r & mask) != mask)) used_r <= 1'b1;
    if (cmd.finish) begin
      out_first_r <= first_r;
      if (act_r == ACT_FREE) begin
        out_status_r <= past_r ? ST_PAST_END : (used_r ? ST_NOT_USED : ST_OK);
      end else if (nofree_r) begin
        out_status_r <= ST_NO_FREE;
      end else begin
        out_status_r <= past_r ? ST_PAST_END : (used_r ? ST_USED : ST_OK);
      end
    end
  end

  assign out_first_sector = out_first_r;
  assign out_status       = out_status_r;

endmodule

FILE: rtl/sector_run_bitmap_allocator.sv
// Channel | Ports                       | Contents (lowest bit first)
// in      | in_tvalid/in_tready         | tuser: action; tdata: start_sector, run_length
// out     | out_tvalid/out_tready       | tdata: first_sector, status
// cfg     | cfg_we, cfg_addr, cfg_wdata | 0 first_data_sector, 1 map_size_bits
//
// One item at a time; the map is a byte-wide RAM, each byte read, then modified and written.
// Allocate: scan bytes up to the first with a clear bit, then set the run byte by byte.
// Free: check the run, then clear it when it is all set; an error ends it early; zero length skips both.
// After reset a clearing pass over all MAP_BYTES bytes runs before the first item is taken.
// A result waits in the output register; the next item is taken meanwhile.
`include "sector_run_bitmap_allocator_assert.svh"

module sector_run_bitmap_allocator #(
  parameter int MAP_BYTES = 4096,
  parameter int MAX_RUN   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // start_sector[31:0], run_length[44:32], zero pad
  input  logic [0:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // first_sector[31:0], status[34:32], zero pad
);
  import sra_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] out_first_sector;
  logic [2:0]  out_status;
  logic [2:0]  wr_cmds;

  sra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sra_dp #(
    .MAP_BYTES (MAP_BYTES),
    .MAX_RUN   (MAX_RUN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_tuser[0]),
    .in_start_sector  (in_tdata[31:0]),
    .in_run_length    (in_tdata[44:32]),
    .cmd              (cmd),
    .sts              (sts),
    .out_first_sector (out_first_sector),
    .out_status       (out_status)
  );

  assign out_tdata = {5'b0, out_status, out_first_sector};
  assign wr_cmds   = {cmd.clr, cmd.mark, cmd.unset};

  `SRA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `SRA_ASSERT_SAME(a_one_writer, 1'b1, $onehot0(wr_cmds))
  `SRA_ASSERT_SAME(a_status_code, out_tvalid, out_status <= ST_NOT_USED)
  `SRA_ASSERT_SAME(a_no_sector_on_fail,
    out_tvalid && (out_status == ST_NO_FREE || out_status == ST_NOT_USED),
    out_first_sector == 32'd0)

endmodule

FILE: verif/tb_sector_run_bitmap_allocator.sv
`timescale 1ns / 100ps

module tb_sector_run_bitmap_allocator;
  import sra_pkg::*;

  localparam int MAP_BYTES    = 4096;
  localparam int MAX_RUN      = 4096;
  localparam int MAP_BITS_CAP = MAP_BYTES * 8;
  localparam int HOLD_CYCLES  = 2000;
  localparam int N_SETTINGS   = 14;

  typedef struct packed {
    logic [31:0] first_sector;
    logic [2:0]  status;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [7:0]      map_bytes [MAP_BYTES];
    logic [31:0]   sector_base;
    logic [15:0]   size_reg;
    alloc_result_t due_q [$];
    int            errors;
    int            n_alloc;
    int            n_free;
    int            status_seen [5];

    function new();
      foreach (map_bytes[i]) map_bytes[i] = 8'h00;
      map_bytes[0] = 8'h01;
      sector_base  = 32'd1;
      size_reg     = 16'd32768;
    endfunction

    function void set_config(logic [31:0] base, logic [15:0] size);
      sector_base = base;
      size_reg    = size;
    endfunction

    function int unsigned map_bits();
      int unsigned s;
      s = size_reg & MAP_SIZE_MASK;
      return (s < MAP_BITS_CAP) ? s : MAP_BITS_CAP;
    endfunction

    function bit bit_set(int unsigned b);
      return map_bytes[(b >> 3) % MAP_BYTES][b % 8];
    endfunction

    function void put_bit(int unsigned b, bit v);
      map_bytes[(b >> 3) % MAP_BYTES][b % 8] = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Applies one accepted item to the map and queues the result it must give.
    function void note_input(logic act, logic [31:0] start, logic [12:0] len_in);
      int unsigned   size, len, pos, b, i, k;
      logic [31:0]   b0;
      bit            found, used, past;
      alloc_result_t r;
      size = map_bits();
      len  = (len_in > MAX_RUN) ? MAX_RUN : len_in;
      r.first_sector = '0;
      r.status       = ST_OK;
      if (act == ACT_ALLOC) begin
        n_alloc++;
        if (len != 0) begin
          found = 1'b0;
          pos   = 0;
          for (i = 0; i < size / 8 && !found; i++) begin
            if (map_bytes[i] != BYTE_FULL) begin
              k = 0;
              while (k < 7 && map_bytes[i][k]) k++;
              pos   = i * 8 + k;
              found = 1'b1;
            end
          end
          if (!found) begin
            r.status = ST_NO_FREE;
          end else begin
            used = 1'b0;
            past = 1'b0;
            for (i = 0; i < len; i++) begin
              b = pos + i;
              if (b >= size) begin
                past = 1'b1;
                break;
              end
              if (bit_set(b)) used = 1'b1;
              put_bit(b, 1'b1);
            end
            r.status       = past ? ST_PAST_END : (used ? ST_USED : ST_OK);
            r.first_sector = 32'(pos + sector_base - 32'd1);
          end
        end
      end else begin
        n_free++;
        if (len != 0) begin
          b0 = start - sector_base + 32'd1;
          if (b0 >= size || len > size - b0) begin
            r.status = ST_PAST_END;
          end else begin
            for (i = 0; i < len; i++)
              if (!bit_set(b0 + i)) r.status = ST_NOT_USED;
            if (r.status == ST_OK)
              for (i = 0; i < len; i++) put_bit(b0 + i, 1'b0);
          end
        end
      end
      status_seen[r.status]++;
      due_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [31:0] sect, logic [2:0] st);
      alloc_result_t want_r;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("result sector %h status %0d with none outstanding",
                                  sect, st));
        return;
      end
      want_r = due_q.pop_front();
      if (sect !== want_r.first_sector)
        report_mismatch($sformatf("first_sector %h, want %h", sect, want_r.first_sector));
      if (st !== want_r.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want_r.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // start_sector[31:0], run_length[44:32], zero pad
  logic [0:0]  in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // first_sector[31:0], status[34:32], zero pad

  alloc_scoreboard sb;
  bit              quiet;
  bit              hold_req;
  int              n_items;
  int              n_settings;

  always #1 clk = ~clk;

  sector_run_bitmap_allocator #(
    .MAP_BYTES (MAP_BYTES),
    .MAX_RUN   (MAX_RUN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[31:0], out_tdata[34:32]);
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(24_000_000);
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(logic act, logic [31:0] start, logic [12:0] len);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, len, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(act, start, len);
    n_items++;
  endtask

  task automatic gap(int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= 48'({$urandom(), $urandom()});
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] base, logic [15:0] size);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FIRST_DATA_SECTOR;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_addr  <= REG_MAP_SIZE_BITS;
    cfg_wdata <= {16'h0000, size};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_config(base, size);
    n_settings++;
  endtask

  function automatic logic [12:0] pick_length(int unsigned size);
    int unsigned r, top, past_top;
    r        = $urandom_range(0, 99);
    top      = (size == 0) ? 1 : ((size < 64) ? size : 64);
    past_top = (size + 16 < 8191) ? size + 16 : 8191;
    if (r < 6)  return '0;
    if (r < 12) return 13'($urandom_range(MAX_RUN - 64, 8191));
    if (r < 18) return 13'($urandom_range(top, past_top));
    return 13'($urandom_range(1, top));
  endfunction

  // mostly runs of bits that are set, so frees succeed; the rest is noise
  function automatic void pick_free(output logic [31:0] s, output logic [12:0] l);
    int unsigned size, b, n, want;
    logic [31:0] base;
    bit          hit;
    size = sb.map_bits();
    base = sb.sector_base;
    hit  = 1'b0;
    b    = 0;
    if (size != 0 && $urandom_range(0, 9) >= 3) begin
      b = $urandom_range(0, size - 1);
      for (n = 0; n < size && !hit; n++) begin
        if (sb.bit_set(b)) hit = 1'b1;
        else b = (b + 1) % size;
      end
    end
    if (hit) begin
      want = $urandom_range(1, 48);
      l    = 13'd1;
      while (l < want && b + l < size && sb.bit_set(b + l)) l++;
      if ($urandom_range(0, 19) == 0) l++;
      s = b + base - 32'd1;
    end else begin
      case ($urandom_range(0, 2))
        0:       s = $urandom();
        1:       s = base - 32'd1 + $urandom_range(0, size + 16);
        default: s = base - 32'd1 - $urandom_range(1, 4);
      endcase
      l = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                      : 13'($urandom_range(0, 16));
    end
  endfunction

  function automatic logic [15:0] setting_size(int p);
    case (p)
      0:  return 16'd64;
      1:  return 16'd8;
      2:  return 16'd256;
      3:  return 16'd100;
      4:  return 16'd24;
      5:  return 16'd4096;
      6:  return 16'd40;
      7:  return 16'd1024;
      8:  return 16'd32768;
      9:  return 16'd128;
      10: return 16'hFFFF;
      11: return 16'd512;
      12: return 16'd16;
      default: return 16'd200;
    endcase
  endfunction

  initial begin
    logic [31:0] base, s;
    logic [12:0] l;
    logic [15:0] size;
    int          count;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_FIRST_DATA_SECTOR;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_ALLOC;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // full-size map (size register above the cap)
    write_config(32'd1, 16'hFFFF);
    send_item(ACT_ALLOC, $urandom(), 13'd0);
    send_item(ACT_ALLOC, $urandom(), 13'd1);
    send_item(ACT_ALLOC, 32'hFFFF_FFFF, 13'h1FFF);
    send_item(ACT_FREE, 32'd2, 13'd4096);
    send_item(ACT_FREE, 32'd2, 13'd1);
    send_item(ACT_FREE, 32'd0, 13'd1);       // reserved bit released
    send_item(ACT_ALLOC, 32'd0, 13'd2);      // lands on bit zero, runs into a set bit
    send_item(ACT_FREE, 32'hFFFF_FFFF, 13'd0);
    send_item(ACT_FREE, 32'hFFFF_FFFF, 13'd1);
    send_item(ACT_FREE, 32'd32767, 13'd2);
    send_item(ACT_FREE, 32'd0, 13'h1FFF);
    drain();

    // tiny map at the top sector base: past end, full map, precedence of past end
    write_config(32'hFFFF_0000, 16'd16);
    send_item(ACT_ALLOC, 32'd0, 13'd20);
    send_item(ACT_ALLOC, 32'd0, 13'd1);
    send_item(ACT_FREE, 32'hFFFF_0002, 13'd3);
    send_item(ACT_FREE, 32'hFFFF_0002, 13'd1);
    send_item(ACT_ALLOC, 32'd0, 13'd20);
    send_item(ACT_FREE, 32'hFFFF_0007, 13'd8);
    send_item(ACT_ALLOC, 32'd0, 13'd8);
    send_item(ACT_FREE, 32'hFFFE_FFFF, 13'd16);
    send_item(ACT_FREE, 32'hFFFE_FFFE, 13'd1);
    drain();

    // size below eight: empty map
    write_config(32'd1, 16'd5);
    send_item(ACT_ALLOC, 32'd0, 13'd1);
    send_item(ACT_FREE, 32'd1, 13'd1);
    drain();

    for (int p = 0; p < N_SETTINGS; p++) begin
      case (p)
        0:       base = 32'd1;
        1:       base = 32'hFFFF_0000;
        default: base = (p % 2 == 0) ? $urandom_range(1, 1000)
                                     : $urandom_range(1, 32'hFFFF_0000);
      endcase
      size = setting_size(p);
      write_config(base, size);
      quiet = (p == N_SETTINGS - 1);
      if (p == 2) hold_req = 1'b1;
      count = (sb.map_bits() >= MAP_BITS_CAP) ? 40 : 140;
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 99) < 55) begin
          send_item(ACT_ALLOC, $urandom(), pick_length(sb.map_bits()));
        end else begin
          pick_free(s, l);
          send_item(ACT_FREE, s, l);
        end
        if (!quiet && $urandom_range(0, 4) == 0) gap($urandom_range(1, 4));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("tb: %0d items (%0d allocate, %0d free) over %0d map settings",
             n_items, sb.n_alloc, sb.n_free, n_settings);
    $display("tb: statuses ok %0d, no free bit %0d, bit used %0d, past end %0d, not used %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_NO_FREE], sb.status_seen[ST_USED],
             sb.status_seen[ST_PAST_END], sb.status_seen[ST_NOT_USED]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sra_pkg.sv
rtl/sra_ctrl.sv
rtl/sra_dp.sv
rtl/sector_run_bitmap_allocator.sv
verif/tb_sector_run_bitmap_allocator.sv
